/* hdl/skvt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the sorted key/value table.
package skvt_pkg;

	// Table size and derived widths.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths of the stream payloads.
	localparam int FUNC_W = 2;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int SLOT_W = 6;
	localparam int FILL_W = 7;
	localparam int IN_W   = 72;
	localparam int OUT_W  = 40;

	// Operation codes carried in the request.
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_FIND   = 2'd1,
		FN_DELETE = 2'd2,
		FN_KEY_AT = 2'd3
	} func_t;

	// Kind of result captured for the response.
	typedef enum logic [1:0] {
		RES_FAIL = 2'd0,
		RES_OK   = 2'd1,
		RES_VAL  = 2'd2,
		RES_KEY  = 2'd3
	} res_t;

	// Source of the table read address.
	typedef enum logic [1:0] {
		RD_MID   = 2'd0,
		RD_LO    = 2'd1,
		RD_SHIFT = 2'd2,
		RD_SLOT  = 2'd3
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    step;
		logic    eq_bump;
		logic    ptr_init;
		logic    sh_wr;
		logic    put;
		logic    del_fin;
		logic    res_set;
		res_t    res_kind;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  search_open;
		logic  key_eq;
		logic  full;
		logic  lo_in;
		logic  shift_more;
		logic  slot_ok;
		logic  out_free;
	} sts_t;

endpackage

/* hdl/skvt_dp.sv */
// Datapath of the sorted key/value table: entry memory, search bounds, shift pointer and result.
module skvt_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skvt_pkg::cmd_t              cmd,
	output skvt_pkg::sts_t              sts,
	input  logic [skvt_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [skvt_pkg::OUT_W-1:0]  m_tdata
);

	localparam int IDX_W = skvt_pkg::IDX_W;
	localparam int CNT_W = skvt_pkg::CNT_W;
	localparam int KEY_W = skvt_pkg::KEY_W;
	localparam int VAL_W = skvt_pkg::VAL_W;
	localparam int ENT_W = KEY_W + VAL_W;

	// Table memory: value in the upper half of each word, key in the lower half.
	logic [ENT_W-1:0] mem_q [skvt_pkg::CAPACITY];
	logic [ENT_W-1:0] rd_q;

	// Request fields held for the whole operation.
	skvt_pkg::func_t                    func_q;
	logic signed [KEY_W-1:0]            key_q;
	logic signed [VAL_W-1:0]            val_q;
	logic [skvt_pkg::SLOT_W-1:0]        slot_q;

	// Search window [lo, hx), probe slot, shift pointer and fill count.
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hx_q;
	logic [IDX_W-1:0] mid_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pending result and output register.
	logic                        res_ok_q;
	logic [KEY_W-1:0]            res_data_q;
	logic                        out_valid_q;
	logic                        out_ok_q;
	logic [KEY_W-1:0]            out_data_q;
	logic [skvt_pkg::FILL_W-1:0] out_fill_q;

	logic [CNT_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid_w;
	logic signed [KEY_W-1:0] rd_key;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        wr_addr;
	logic [ENT_W-1:0]        wr_data;
	logic                    wr_en;
	logic [CNT_W-1:0]        sh_src;
	logic                    go_left;
	logic                    is_insert;

	// Probe midpoint of the inclusive window [lo, hx-1].
	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CNT_W+1)'(1);
	assign mid_w   = IDX_W'(mid_sum >> 1);

	assign rd_key    = $signed(rd_q[KEY_W-1:0]);
	assign is_insert = (func_q == skvt_pkg::FN_INSERT);

	// Lower-bound search moves left on equal keys; exact search stops there instead.
	assign go_left = (key_q < rd_key) || ((key_q == rd_key) && is_insert);

	// Shift source: one below the pointer when opening a gap, one above when closing it.
	assign sh_src = is_insert ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));

	// Read address selection.
	always_comb begin
		case (cmd.rd_sel)
			skvt_pkg::RD_MID:   rd_addr = mid_w;
			skvt_pkg::RD_LO:    rd_addr = lo_q[IDX_W-1:0];
			skvt_pkg::RD_SHIFT: rd_addr = sh_src[IDX_W-1:0];
			skvt_pkg::RD_SLOT:  rd_addr = IDX_W'(slot_q);
			default:            rd_addr = mid_w;
		endcase
	end

	// Write port: a moved entry during a shift, or the new pair on insert.
	assign wr_en   = cmd.sh_wr || cmd.put;
	assign wr_addr = cmd.put ? lo_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	assign wr_data = cmd.put ? {val_q, key_q} : rd_q;

	// Single-port style memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Request capture, probe slot and pending result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= skvt_pkg::func_t'(s_tdata[1:0]);
			key_q  <= $signed(s_tdata[33:2]);
			val_q  <= $signed(s_tdata[65:34]);
			slot_q <= s_tdata[71:66];
		end
		if (cmd.rd_en && (cmd.rd_sel == skvt_pkg::RD_MID)) begin
			mid_q <= mid_w;
		end
		if (cmd.res_set) begin
			res_ok_q <= (cmd.res_kind != skvt_pkg::RES_FAIL);
			case (cmd.res_kind)
				skvt_pkg::RES_VAL: res_data_q <= rd_q[ENT_W-1:KEY_W];
				skvt_pkg::RES_KEY: res_data_q <= rd_q[KEY_W-1:0];
				default:           res_data_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_ok_q   <= res_ok_q;
			out_data_q <= res_data_q;
			out_fill_q <= skvt_pkg::FILL_W'(count_q);
		end
	end

	// Search bounds, shift pointer, fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q        <= '0;
			hx_q        <= '0;
			ptr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				lo_q <= '0;
				hx_q <= count_q;
			end else if (cmd.step) begin
				if (go_left) begin
					hx_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end else if (cmd.eq_bump && (key_q == rd_key)) begin
				lo_q <= lo_q + CNT_W'(1);
			end

			if (cmd.ptr_init) begin
				ptr_q <= is_insert ? count_q : CNT_W'(mid_q);
			end else if (cmd.sh_wr) begin
				ptr_q <= sh_src;
			end

			if (cmd.put) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.del_fin) begin
				count_q <= count_q - CNT_W'(1);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.func        = func_q;
		sts.search_open = (lo_q < hx_q);
		sts.key_eq      = (key_q == rd_key);
		sts.full        = (count_q == CNT_W'(skvt_pkg::CAPACITY));
		sts.lo_in       = (lo_q < count_q);
		sts.shift_more  = is_insert ? (ptr_q > lo_q)
		                            : (({1'b0, ptr_q} + (CNT_W+1)'(1)) < {1'b0, count_q});
		sts.slot_ok     = (32'(slot_q) < 32'(count_q));
		sts.out_free    = !out_valid_q || m_tready;
	end

	// Output channel: success, data, fill from the lowest bit up.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_fill_q, out_data_q, out_ok_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(skvt_pkg::CAPACITY))
		else $error("fill count beyond capacity");
	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (count_q < CNT_W'(skvt_pkg::CAPACITY)))
		else $error("insert into a full table");
	a_del_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_fin |-> (count_q != '0))
		else $error("delete from an empty table");
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("result overwrites one not yet transferred");
`endif

endmodule

/* hdl/skvt_ctrl.sv */
// Controller state machine of the sorted key/value table: sequences search, shift and response.
module skvt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	input  skvt_pkg::sts_t sts,
	output skvt_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_DISPATCH  = 11'b000_0000_0010,
		ST_PROBE_RD  = 11'b000_0000_0100,
		ST_PROBE_CMP = 11'b000_0000_1000,
		ST_EQ_RD     = 11'b000_0001_0000,
		ST_EQ_CMP    = 11'b000_0010_0000,
		ST_SHIFT_CHK = 11'b000_0100_0000,
		ST_SHIFT_WR  = 11'b000_1000_0000,
		ST_AT_RD     = 11'b001_0000_0000,
		ST_AT_GET    = 11'b010_0000_0000,
		ST_RESP      = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.rd_sel   = skvt_pkg::RD_MID;
		cmd.res_kind = skvt_pkg::RES_FAIL;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.func)
					skvt_pkg::FN_INSERT: begin
						if (sts.full) begin
							cmd.res_set = 1'b1;
							state_d     = ST_RESP;
						end else begin
							state_d = ST_PROBE_RD;
						end
					end
					skvt_pkg::FN_KEY_AT: state_d = ST_AT_RD;
					default:             state_d = ST_PROBE_RD;
				endcase
			end
			ST_PROBE_RD: begin
				if (sts.search_open) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skvt_pkg::RD_MID;
					state_d    = ST_PROBE_CMP;
				end else if (sts.func == skvt_pkg::FN_INSERT) begin
					// Lower bound found; check for an equal key there.
					if (sts.lo_in) begin
						state_d = ST_EQ_RD;
					end else begin
						cmd.ptr_init = 1'b1;
						state_d      = ST_SHIFT_CHK;
					end
				end else begin
					cmd.res_set = 1'b1;
					state_d     = ST_RESP;
				end
			end
			ST_PROBE_CMP: begin
				if (sts.key_eq && (sts.func == skvt_pkg::FN_FIND)) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = skvt_pkg::RES_VAL;
					state_d      = ST_RESP;
				end else if (sts.key_eq && (sts.func == skvt_pkg::FN_DELETE)) begin
					cmd.ptr_init = 1'b1;
					state_d      = ST_SHIFT_CHK;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_PROBE_RD;
				end
			end
			ST_EQ_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = skvt_pkg::RD_LO;
				state_d    = ST_EQ_CMP;
			end
			ST_EQ_CMP: begin
				cmd.eq_bump  = 1'b1;
				cmd.ptr_init = 1'b1;
				state_d      = ST_SHIFT_CHK;
			end
			ST_SHIFT_CHK: begin
				if (sts.shift_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skvt_pkg::RD_SHIFT;
					state_d    = ST_SHIFT_WR;
				end else begin
					// Shift finished: place the new pair or drop the last slot.
					cmd.put      = (sts.func == skvt_pkg::FN_INSERT);
					cmd.del_fin  = (sts.func != skvt_pkg::FN_INSERT);
					cmd.res_set  = 1'b1;
					cmd.res_kind = skvt_pkg::RES_OK;
					state_d      = ST_RESP;
				end
			end
			ST_SHIFT_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = ST_SHIFT_CHK;
			end
			ST_AT_RD: begin
				if (sts.slot_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skvt_pkg::RD_SLOT;
					state_d    = ST_AT_GET;
				end else begin
					cmd.res_set = 1'b1;
					state_d     = ST_RESP;
				end
			end
			ST_AT_GET: begin
				cmd.res_set  = 1'b1;
				cmd.res_kind = skvt_pkg::RES_KEY;
				state_d      = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/sorted_key_value_table_top.sv */
// Top level of the sorted key/value table: controller and datapath joined by command and status.
//
//  Channel   Direction  Ports                          Payload (lowest bit first)
//  request   in         s_tvalid s_tready s_tdata      func, key, item_value, slot
//  response  out        m_tvalid m_tready m_tdata      success, data, fill
//
// One request at a time; each gives exactly one response transfer.
// A search probe is a registered table read followed by a compare, with up to
// log2(fill)+1 probes; insert and delete add a table read and a write per moved entry.
// The controller takes no new request until it has loaded the response into the output
// register; a response still waiting in the output register holds the controller longer.
// Reset clears the fill count and the controller; table contents need no clearing.
// A new request is taken while the previous response still waits in the output register.
module sorted_key_value_table_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [skvt_pkg::IN_W-1:0]   s_tdata,  // func[1:0], key[33:2], item_value[65:34], slot[71:66]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [skvt_pkg::OUT_W-1:0]  m_tdata   // success[0], data[32:1], fill[39:33]
);

	skvt_pkg::cmd_t cmd;
	skvt_pkg::sts_t sts;

	// Sequencer.
	skvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Table storage and arithmetic.
	skvt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* tb/sv/sorted_key_value_table_checker.sv */
`timescale 1ns / 100ps
// Checker for the sorted key/value table: tracks the table contents from request transfers and compares responses.
module sorted_key_value_table_checker
	import skvt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // func[1:0], key[33:2], item_value[65:34], slot[71:66]
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // success[0], data[32:1], fill[39:33]
	output int               fail_count,
	output int               pending
);

	// One response as the table should give it.
	typedef struct packed {
		logic              success;
		logic [VAL_W-1:0]  data;
		logic [FILL_W-1:0] fill;
	} table_reply_t;

	// Shadow copy of the table.
	logic signed [KEY_W-1:0] key_tab [CAPACITY];
	logic signed [VAL_W-1:0] val_tab [CAPACITY];
	int                      held = 0;

	table_reply_t            reply_q [$];
	table_reply_t            want;
	table_reply_t            got;
	int                      mismatches = 0;

	// First slot whose key is not below k.
	function automatic int lower_slot(input logic signed [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = held - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (k <= key_tab[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return lo;
	endfunction

	// Slot of the first equal key that the probes reach, or -1 when absent.
	function automatic int hit_slot(input logic signed [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = held - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (k < key_tab[mid]) begin
				hi = mid - 1;
			end else if (k > key_tab[mid]) begin
				lo = mid + 1;
			end else begin
				return mid;
			end
		end
		return -1;
	endfunction

	// Apply one request to the shadow table and form the response it should give.
	task automatic apply_request(input logic [IN_W-1:0] req, output table_reply_t r);
		func_t                   op;
		logic signed [KEY_W-1:0] k;
		logic signed [VAL_W-1:0] v;
		logic [SLOT_W-1:0]       sl;
		int                      idx;
		op = func_t'(req[FUNC_W-1:0]);
		k  = req[FUNC_W +: KEY_W];
		v  = req[FUNC_W+KEY_W +: VAL_W];
		sl = req[FUNC_W+KEY_W+VAL_W +: SLOT_W];
		r  = '0;
		case (op)
			FN_INSERT: begin
				if (held < CAPACITY) begin
					idx = lower_slot(k);
					// An equal key already at the lower bound keeps its place; the new pair lands just after it.
					if (idx < held && key_tab[idx] == k) idx++;
					for (int i = held - 1; i >= idx; i--) begin
						key_tab[i+1] = key_tab[i];
						val_tab[i+1] = val_tab[i];
					end
					key_tab[idx] = k;
					val_tab[idx] = v;
					held++;
					r.success = 1'b1;
				end
			end
			FN_FIND: begin
				idx = hit_slot(k);
				if (idx >= 0) begin
					r.success = 1'b1;
					r.data    = val_tab[idx];
				end
			end
			FN_DELETE: begin
				idx = hit_slot(k);
				if (idx >= 0) begin
					for (int i = idx; i < held - 1; i++) begin
						key_tab[i] = key_tab[i+1];
						val_tab[i] = val_tab[i+1];
					end
					held--;
					r.success = 1'b1;
				end
			end
			FN_KEY_AT: begin
				if (int'(sl) < held) begin
					r.success = 1'b1;
					r.data    = key_tab[sl];
				end
			end
		endcase
		r.fill = FILL_W'(held);
	endtask

	// Response transfers are checked before the request of the same edge is added.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			reply_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.success = m_tdata[0];
				got.data    = m_tdata[32:1];
				got.fill    = m_tdata[39:33];
				if (reply_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response with nothing outstanding: success %0b data %h fill %0d",
							$realtime, got.success, got.data, got.fill);
				end else begin
					want = reply_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: expected success %0b data %h fill %0d, got success %0b data %h fill %0d",
								$realtime, want.success, want.data, want.fill,
								got.success, got.data, got.fill);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tdata, want);
				reply_q.push_back(want);
			end
			fail_count <= mismatches;
			pending    <= reply_q.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the sorted key/value table: clock, reset, request and response stimulus, and verdict.
module tb;
	import skvt_pkg::*;

	localparam int N_RANDOM     = 1430;
	localparam int POOL_SIZE    = 24;
	localparam int HOLD_START   = 6000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 200;
	localparam int LIMIT        = 1500000;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	logic             quiet    = 1'b0;
	int               cycles   = 0;
	int               fail_count;
	int               pending;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	always #6 clk = ~clk;

	sorted_key_value_table_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sorted_key_value_table_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [IN_W-1:0] pack_req(input func_t op, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v, input logic [SLOT_W-1:0] sl);
		return {sl, v, k, op};
	endfunction

	// Small keys collide often, so finds, deletes and duplicates get exercised.
	function automatic logic [KEY_W-1:0] fresh_key();
		if ($urandom_range(0, 1) == 0)
			return KEY_W'($urandom_range(0, 200)) - KEY_W'(100);
		return $urandom();
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom();
	endfunction

	// Offer one request, after an optional gap, until the block takes the transfer.
	task automatic send_req(input logic [IN_W-1:0] req);
		logic taken;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tdata  <= req;
		s_tvalid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
	endtask

	// Response side: random ready bursts, and one long hold-off so the block backs up.
	initial begin
		int elapsed;
		int n;
		bit held_off;
		elapsed  = 0;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = $urandom_range(1, 16);
			if (!held_off && elapsed >= HOLD_START) begin
				m_tready <= 1'b0;
				n = HOLD_CYCLES;
				held_off = 1'b1;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
			end
			repeat (n) @(posedge clk);
			elapsed += n;
		end
	end

	// Request side: directed requests, then random phases that grow, shrink or mix the table.
	initial begin
		int    mode;
		int    pick;
		int    ins_pct;
		int    find_pct;
		int    del_pct;
		func_t op;
		mode = 0;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = '0;
		for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = fresh_key();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: every lookup fails.
		send_req(pack_req(FN_KEY_AT, '0, '0, '0));
		send_req(pack_req(FN_FIND, '0, '0, '0));
		send_req(pack_req(FN_DELETE, '0, '0, '0));
		// Extreme keys and values, then duplicate keys.
		send_req(pack_req(FN_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, '0));
		send_req(pack_req(FN_INSERT, 32'h8000_0000, 32'h8000_0000, '0));
		send_req(pack_req(FN_INSERT, '0, 32'd1, '0));
		send_req(pack_req(FN_INSERT, '0, 32'd2, '0));
		send_req(pack_req(FN_INSERT, '0, 32'd3, '0));
		send_req(pack_req(FN_FIND, 32'h7fff_ffff, '0, '0));
		send_req(pack_req(FN_FIND, 32'h8000_0000, '0, '0));
		send_req(pack_req(FN_FIND, '0, '0, '0));
		// Slot reads inside and outside the occupied range.
		send_req(pack_req(FN_KEY_AT, '0, '0, 6'd0));
		send_req(pack_req(FN_KEY_AT, '0, '0, 6'd4));
		send_req(pack_req(FN_KEY_AT, '0, '0, 6'd5));
		send_req(pack_req(FN_KEY_AT, '0, '0, 6'd63));
		// Deletes of present and absent keys.
		send_req(pack_req(FN_DELETE, '0, '0, '0));
		send_req(pack_req(FN_FIND, 32'd12345, '0, '0));
		send_req(pack_req(FN_DELETE, 32'd12345, '0, '0));
		send_req(pack_req(FN_DELETE, 32'h8000_0000, '0, '0));
		send_req(pack_req(FN_DELETE, 32'h7fff_ffff, '0, '0));
		send_req(pack_req(FN_INSERT, 32'hffff_ffff, 32'hffff_ffff, 6'd63));
		send_req(pack_req(FN_INSERT, 32'd1, '0, '0));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) begin
				mode = (i == 0) ? 0 : $urandom_range(0, 2);
				repeat (4) key_pool[$urandom_range(3, POOL_SIZE - 1)] = fresh_key();
			end
			if (i == N_RANDOM - 120) quiet <= 1'b1;
			case (mode)
				0: begin
					ins_pct = 70; find_pct = 12; del_pct = 5;
				end
				1: begin
					ins_pct = 15; find_pct = 15; del_pct = 55;
				end
				default: begin
					ins_pct = 30; find_pct = 25; del_pct = 25;
				end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < ins_pct) begin
				op = FN_INSERT;
			end else if (pick < ins_pct + find_pct) begin
				op = FN_FIND;
			end else if (pick < ins_pct + find_pct + del_pct) begin
				op = FN_DELETE;
			end else begin
				op = FN_KEY_AT;
			end
			send_req(pack_req(op, pick_key(), $urandom(), SLOT_W'($urandom_range(0, 63))));
		end
		s_tvalid <= 1'b0;

		// Let the last responses come out, then allow for one more request's latency.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
